// ----- rtl/kbt_pkg.sv -----
// Package for the keyed barrier table: table size, command and action codes.
// No dependencies; used by the top level and the testbench.
package kbt_pkg;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] CMD_OPEN    = 2'd0;
  localparam logic [1:0] CMD_WAIT    = 2'd1;
  localparam logic [1:0] CMD_DESTROY = 2'd2;

  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_BLOCK   = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

endpackage

// ----- rtl/kbt_if.sv -----
// Request and response channel interfaces of the keyed barrier table.
// Valid/ready handshake; depends on nothing.
interface kbt_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  cmd;
  logic signed [31:0] barrier_key;
  logic        [15:0] goal_count;
  logic        [3:0]  slot_index;

  modport source (output valid, cmd, barrier_key, goal_count, slot_index, input ready);
  modport sink   (input valid, cmd, barrier_key, goal_count, slot_index, output ready);
endinterface

interface kbt_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  result_slot;
  logic        table_full;
  logic [1:0]  action;
  logic [15:0] released_count;

  modport source (output valid, result_slot, table_full, action, released_count, input ready);
  modport sink   (input valid, result_slot, table_full, action, released_count, output ready);
endinterface

// ----- rtl/keyed_barrier_table.sv -----
// Keyed barrier table: open / wait / destroy on SLOTS barrier slots.
// Open scans one slot a cycle through a single key comparator; a key match
// ends the scan early, and the last step waits until the output register is
// free. Wait and destroy are done in ST_EXEC, which also waits for it.
// One request at a time; the next is taken once the result is in the output
// register. Reset (async, active low) frees all slots; key, goal and count
// storage is not reset, since a free slot's fields are never used.
module keyed_barrier_table
  import kbt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  kbt_req_if.sink     req_i,
  kbt_rsp_if.source   rsp_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EXEC} state_e;

  state_e            state_q, state_d;
  logic [1:0]        cmd_q;
  logic [31:0]       key_q;
  logic [15:0]       goal_q;
  logic [3:0]        idx_q;
  logic [IDX_W-1:0]  scan_q, scan_d;
  logic [IDX_W-1:0]  free_q, free_d;
  logic              free_found_q, free_found_d;

  // slot storage
  logic [SLOTS-1:0]  use_q;
  logic [31:0]       key_mem  [SLOTS];
  logic [15:0]       goal_mem [SLOTS];
  logic [15:0]       cnt_mem  [SLOTS];

  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic              rd_use;
  logic [31:0]       rd_key;
  logic [15:0]       rd_goal, rd_cnt;
  logic              wr_open, wr_cnt_en, wr_free;
  logic [15:0]       wr_cnt;

  logic              rsp_valid_q;
  logic [3:0]        rsp_slot_q, rsp_slot_d;
  logic              rsp_full_q, rsp_full_d;
  logic [1:0]        rsp_act_q, rsp_act_d;
  logic [15:0]       rsp_rel_q, rsp_rel_d;
  logic              finish;

  logic              out_free;
  logic              idx_ok;
  logic              hit, last;
  logic [15:0]       cnt_inc;
  logic [IDX_W-1:0]  idx_addr;

  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign idx_addr = IDX_W'(idx_q);
  assign idx_ok   = (32'(idx_q) < 32'(SLOTS));

  assign rd_addr = (state_q == ST_SCAN) ? scan_q : idx_addr;
  assign rd_use  = use_q[rd_addr];
  assign rd_key  = key_mem[rd_addr];
  assign rd_goal = goal_mem[rd_addr];
  assign rd_cnt  = cnt_mem[rd_addr];

  assign hit     = rd_use && (rd_key == key_q);
  assign last    = (32'(scan_q) == 32'(SLOTS - 1));
  assign cnt_inc = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + 16'd1;

  assign req_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    free_d       = free_q;
    free_found_d = free_found_q;
    finish       = 1'b0;
    rsp_slot_d   = idx_q;
    rsp_full_d   = 1'b0;
    rsp_act_d    = ACT_NONE;
    rsp_rel_d    = 16'd0;
    wr_addr      = rd_addr;
    wr_open      = 1'b0;
    wr_cnt_en    = 1'b0;
    wr_free      = 1'b0;
    wr_cnt       = 16'd0;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          scan_d       = '0;
          free_found_d = 1'b0;
          state_d      = (req_i.cmd == CMD_OPEN) ? ST_SCAN : ST_EXEC;
        end
      end
      ST_SCAN: begin
        if (!rd_use && !free_found_q) begin
          free_d       = scan_q;
          free_found_d = 1'b1;
        end
        if (hit || last) begin
          // final step waits until the output register can take the result
          if (out_free) begin
            finish  = 1'b1;
            state_d = ST_IDLE;
            if (hit) begin
              rsp_slot_d = 4'(scan_q);
            end else if (free_found_q || !rd_use) begin
              wr_addr    = free_found_q ? free_q : scan_q;
              wr_open    = 1'b1;
              rsp_slot_d = 4'(wr_addr);
            end else begin
              rsp_slot_d = 4'd0;
              rsp_full_d = 1'b1;
            end
          end
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
          if (cmd_q == CMD_WAIT && idx_ok && rd_use) begin
            wr_cnt_en = 1'b1;
            if (cnt_inc != rd_goal) begin
              rsp_act_d = ACT_BLOCK;
              wr_cnt    = cnt_inc;
            end else begin
              rsp_act_d = ACT_RELEASE;
              rsp_rel_d = cnt_inc - 16'd1;
            end
          end else if (cmd_q == CMD_DESTROY && idx_ok) begin
            rsp_act_d = ACT_RELEASE;
            rsp_rel_d = rd_use ? rd_cnt : 16'd0;
            wr_free   = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      scan_q       <= '0;
      free_q       <= '0;
      free_found_q <= 1'b0;
      rsp_valid_q  <= 1'b0;
      use_q        <= '0;
    end else begin
      state_q      <= state_d;
      scan_q       <= scan_d;
      free_q       <= free_d;
      free_found_q <= free_found_d;
      if (finish) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (wr_open) begin
        use_q[wr_addr] <= 1'b1;
      end else if (wr_free) begin
        use_q[wr_addr] <= 1'b0;
      end
    end
  end

  // request capture, slot fields and response payload
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      cmd_q  <= req_i.cmd;
      key_q  <= req_i.barrier_key;
      goal_q <= req_i.goal_count;
      idx_q  <= req_i.slot_index;
    end
    if (wr_open) begin
      key_mem[wr_addr]  <= key_q;
      goal_mem[wr_addr] <= goal_q;
      cnt_mem[wr_addr]  <= 16'd0;
    end else if (wr_cnt_en) begin
      cnt_mem[wr_addr]  <= wr_cnt;
    end
    if (finish) begin
      rsp_slot_q <= rsp_slot_d;
      rsp_full_q <= rsp_full_d;
      rsp_act_q  <= rsp_act_d;
      rsp_rel_q  <= rsp_rel_d;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.result_slot    = rsp_slot_q;
  assign rsp_o.table_full     = rsp_full_q;
  assign rsp_o.action         = rsp_act_q;
  assign rsp_o.released_count = rsp_rel_q;

endmodule

// ----- verif/keyed_barrier_table_tb.sv -----
// Self-checking testbench of the keyed barrier table: directed table, table fill,
// then random requests, each checked against typed expectations or an in-bench barrier predictor.
// Depends on kbt_pkg, kbt_req_if / kbt_rsp_if and keyed_barrier_table.
module keyed_barrier_table_tb;
  import kbt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_RSVD    = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS = 200;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned KEY_POOL = 20;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] key;
    logic [15:0]        goal;
    logic [3:0]         idx;
  } bar_req_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic        full;
    logic [1:0]  act;
    logic [15:0] rel;
  } bar_rsp_t;

  typedef struct {
    bar_req_t req;
    bit       typed;
    bar_rsp_t rsp;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  kbt_req_if req_if ();
  kbt_rsp_if rsp_if ();

  keyed_barrier_table u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // predictor copy of the table
  bit          bt_used  [SLOTS];
  logic [31:0] bt_key   [SLOTS];
  logic [15:0] bt_goal  [SLOTS];
  logic [15:0] bt_count [SLOTS];

  bar_rsp_t    pending_rsp[$];
  dir_row_t    dir_rows[$];
  logic [31:0] key_pool [KEY_POOL];

  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned hold_cycles;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic bar_rsp_t predict_barrier(input bar_req_t r);
    bar_rsp_t o;
    bit       found;
    o.slot = r.idx;
    o.full = 1'b0;
    o.act  = ACT_NONE;
    o.rel  = '0;
    found  = 1'b0;
    case (r.cmd)
      CMD_OPEN: begin
        for (int i = 0; i < SLOTS && !found; i++) begin
          if (bt_used[i] && bt_key[i] == r.key) begin
            o.slot = i[3:0];
            found  = 1'b1;
          end
        end
        for (int i = 0; i < SLOTS && !found; i++) begin
          if (!bt_used[i]) begin
            bt_used[i]  = 1'b1;
            bt_key[i]   = r.key;
            bt_goal[i]  = r.goal;
            bt_count[i] = '0;
            o.slot      = i[3:0];
            found       = 1'b1;
          end
        end
        if (!found) begin
          o.slot = '0;
          o.full = 1'b1;
        end
      end
      CMD_WAIT: begin
        if (int'(r.idx) < SLOTS && bt_used[r.idx]) begin
          if (bt_count[r.idx] != COUNT_MAX) bt_count[r.idx] = bt_count[r.idx] + 16'd1;
          if (bt_count[r.idx] != bt_goal[r.idx]) begin
            o.act = ACT_BLOCK;
          end else begin
            o.act = ACT_RELEASE;
            o.rel = bt_count[r.idx] - 16'd1;
            bt_count[r.idx] = '0;
          end
        end
      end
      CMD_DESTROY: begin
        if (int'(r.idx) < SLOTS) begin
          o.act = ACT_RELEASE;
          o.rel = bt_count[r.idx];
          bt_used[r.idx]  = 1'b0;
          bt_key[r.idx]   = '0;
          bt_goal[r.idx]  = '0;
          bt_count[r.idx] = '0;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // response monitor
  always @(posedge clk_i) begin
    bar_rsp_t e;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t ns: response with none expected, expected none actual %0h",
                   $time, {rsp_if.result_slot, rsp_if.table_full, rsp_if.action,
                           rsp_if.released_count});
      end else begin
        e = pending_rsp.pop_front();
        check_field("result_slot", 32'(e.slot), 32'(rsp_if.result_slot));
        check_field("table_full", 32'(e.full), 32'(rsp_if.table_full));
        check_field("action", 32'(e.act), 32'(rsp_if.action));
        check_field("released_count", 32'(e.rel), 32'(rsp_if.released_count));
      end
    end
  end

  // response side: random back-pressure plus a long hold-off on request
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_req(input bar_req_t r, input bit typed, input bar_rsp_t typed_rsp);
    bar_rsp_t p;
    while (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.cmd         <= r.cmd;
    req_if.barrier_key <= r.key;
    req_if.goal_count  <= r.goal;
    req_if.slot_index  <= r.idx;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    p = predict_barrier(r);
    pending_rsp.push_back(typed ? typed_rsp : p);
    @(negedge clk_i);
  endtask

  task automatic send_plain(input logic [1:0] cmd, input logic [31:0] key,
                            input logic [15:0] goal, input logic [3:0] idx);
    bar_req_t r;
    r = '{cmd: cmd, key: key, goal: goal, idx: idx};
    send_req(r, 1'b0, '0);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_rsp.size() != 0) @(negedge clk_i);
  endtask

  task automatic add_row(input logic [1:0] cmd, input logic [31:0] key,
                         input logic [15:0] goal, input logic [3:0] idx, input bit typed,
                         input logic [3:0] e_slot, input logic e_full,
                         input logic [1:0] e_act, input logic [15:0] e_rel);
    dir_row_t row;
    row.req   = '{cmd: cmd, key: key, goal: goal, idx: idx};
    row.typed = typed;
    row.rsp   = '{slot: e_slot, full: e_full, act: e_act, rel: e_rel};
    dir_rows.push_back(row);
  endtask

  function automatic bar_req_t random_request();
    bar_req_t    r;
    int unsigned pick;
    int unsigned live[$];
    for (int i = 0; i < SLOTS; i++) if (bt_used[i]) live.push_back(i);
    r.key  = key_pool[$urandom_range(KEY_POOL - 1)];
    pick   = $urandom_range(99);
    r.goal = (pick < 70) ? 16'($urandom_range(4, 1)) :
             (pick < 85) ? 16'd0 : 16'($urandom);
    r.idx  = 4'($urandom);
    pick   = $urandom_range(99);
    if (pick < 30) begin
      r.cmd = CMD_OPEN;
    end else if (pick < 78) begin
      r.cmd = CMD_WAIT;
      if (live.size() != 0 && $urandom_range(99) < 85)
        r.idx = 4'(live[$urandom_range(live.size() - 1)]);
    end else if (pick < 94) begin
      r.cmd = CMD_DESTROY;
      if (live.size() != 0 && $urandom_range(99) < 70)
        r.idx = 4'(live[$urandom_range(live.size() - 1)]);
    end else if (pick < 97) begin
      r.cmd = CMD_RSVD;
    end else begin
      r.cmd = CMD_OPEN;
      r.key = $urandom;
    end
    return r;
  endfunction

  initial begin
    req_if.valid       = 1'b0;
    req_if.cmd         = CMD_OPEN;
    req_if.barrier_key = '0;
    req_if.goal_count  = '0;
    req_if.slot_index  = '0;
    err_cnt      = 0;
    cycle_cnt    = 0;
    hold_cycles  = 0;
    snd_idle_pct = 34;
    rcv_idle_pct = 68;
    for (int i = 0; i < SLOTS; i++) begin
      bt_used[i]  = 1'b0;
      bt_key[i]   = '0;
      bt_goal[i]  = '0;
      bt_count[i] = '0;
    end
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;

    // directed requests; typed expectations only where obvious
    add_row(CMD_WAIT,    32'h0,         16'h0,    4'd0,  1, 4'd0,  0, ACT_NONE,    16'd0);
    add_row(CMD_DESTROY, 32'h0,         16'h0,    4'd15, 1, 4'd15, 0, ACT_RELEASE, 16'd0);
    add_row(CMD_RSVD,    32'hFFFF_FFFF, 16'hFFFF, 4'd9,  1, 4'd9,  0, ACT_NONE,    16'd0);
    add_row(CMD_OPEN,    32'h8000_0000, 16'h0,    4'd5,  1, 4'd0,  0, ACT_NONE,    16'd0);
    add_row(CMD_OPEN,    32'h7FFF_FFFF, 16'hFFFF, 4'd10, 1, 4'd1,  0, ACT_NONE,    16'd0);
    add_row(CMD_OPEN,    32'h0,         16'h1,    4'd15, 1, 4'd2,  0, ACT_NONE,    16'd0);
    // same key again: goal is ignored
    add_row(CMD_OPEN,    32'h8000_0000, 16'h7,    4'd3,  1, 4'd0,  0, ACT_NONE,    16'd0);
    add_row(CMD_WAIT,    32'h0,         16'h0,    4'd2,  1, 4'd2,  0, ACT_RELEASE, 16'd0);
    // goal of zero never releases
    add_row(CMD_WAIT,    32'h0,         16'h0,    4'd0,  1, 4'd0,  0, ACT_BLOCK,   16'd0);
    add_row(CMD_WAIT,    32'h0,         16'h0,    4'd0,  1, 4'd0,  0, ACT_BLOCK,   16'd0);
    add_row(CMD_DESTROY, 32'h0,         16'h0,    4'd0,  1, 4'd0,  0, ACT_RELEASE, 16'd2);
    add_row(CMD_OPEN,    32'h3,         16'h2,    4'd0,  0, '0, 0, ACT_NONE, '0);
    add_row(CMD_WAIT,    32'h0,         16'h0,    4'd0,  0, '0, 0, ACT_NONE, '0);
    add_row(CMD_WAIT,    32'h0,         16'h0,    4'd0,  0, '0, 0, ACT_NONE, '0);
    add_row(CMD_WAIT,    32'h0,         16'h0,    4'd1,  0, '0, 0, ACT_NONE, '0);
    add_row(CMD_DESTROY, 32'h0,         16'h0,    4'd1,  0, '0, 0, ACT_NONE, '0);
    add_row(CMD_WAIT,    32'h0,         16'h0,    4'd1,  0, '0, 0, ACT_NONE, '0);
    add_row(CMD_OPEN,    32'h0,         16'h9,    4'd6,  0, '0, 0, ACT_NONE, '0);
    add_row(CMD_DESTROY, 32'h0,         16'h0,    4'd14, 0, '0, 0, ACT_NONE, '0);
    add_row(CMD_OPEN,    32'hFFFF_FFFF, 16'h3,    4'd0,  0, '0, 0, ACT_NONE, '0);
    add_row(CMD_WAIT,    32'h5555_AAAA, 16'hAAAA, 4'd15, 0, '0, 0, ACT_NONE, '0);

    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
    drain_results();

    // fill the table, overflow it, then empty it, at full speed
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    for (int n = 0; n < 17; n++) send_plain(CMD_OPEN, 32'hC000_0000 + n, 16'($urandom), 4'd0);
    send_plain(CMD_OPEN, 32'h3, 16'd5, 4'd0);
    for (int n = 0; n < SLOTS; n++) send_plain(CMD_DESTROY, '0, '0, 4'(n));
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 68 : 0;
      rcv_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 34 : 0;
      if (ph == 1)
        for (int n = 0; n < 18; n++) send_plain(CMD_OPEN, $urandom, 16'($urandom_range(3, 1)), '0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 60) hold_cycles = 300;
        send_req(random_request(), 1'b0, '0);
      end
      // sender waits for every outstanding response between phases
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- keyed_barrier_table.f -----
rtl/kbt_pkg.sv
rtl/kbt_if.sv
rtl/keyed_barrier_table.sv
verif/keyed_barrier_table_tb.sv
